[design/point_in_convex_polygon_unit_assert.svh]
// Assertion macros shared by the polygon test unit and its edge pipeline.
`ifndef POINT_IN_CONVEX_POLYGON_UNIT_ASSERT_SVH
`define POINT_IN_CONVEX_POLYGON_UNIT_ASSERT_SVH

// Concurrent check on an explicit clock and active-low reset.
`define PICP_ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("picp assertion failed");

// Concurrent check on the house clock and reset.
`define PICP_ASSERT(name, prop) \
  `PICP_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

[design/picp_pkg.sv]
// Types, constants and codes of the point-in-convex-polygon unit.
package picp_pkg;

  localparam int MaxVertices = 16;
  localparam int AddrW       = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);

  localparam int FuncW     = 2;
  localparam int CoordW    = 24;
  localparam int CoefW     = 16;
  localparam int CountOutW = 5;
  localparam int CfgIdxW   = 3;
  localparam int FracW     = 14;

  localparam int PtProdW = CoefW + CoordW;      // one coefficient times one component
  localparam int AccW    = PtProdW + 2;         // sum of four products
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;

  localparam logic signed [CoefW-1:0] CoefOne = CoefW'(1 << FracW);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // Control into the edge pipeline.
  typedef struct packed {
    logic vld;    // vertex read data valid this cycle
    logic first;  // that vertex opens the walk, no edge yet
    logic clr;    // start of a new walk
  } edge_ctl_t;

  // Status out of the edge pipeline.
  typedef struct packed {
    logic busy;
    logic outside;
  } edge_sts_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_R0_C0 = 3'd0,
    CFG_R0_C1 = 3'd1,
    CFG_R0_C2 = 3'd2,
    CFG_R0_C3 = 3'd3,
    CFG_R1_C0 = 3'd4,
    CFG_R1_C1 = 3'd5,
    CFG_R1_C2 = 3'd6,
    CFG_R1_C3 = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROJ,
    ST_ACC,
    ST_SAT,
    ST_EDGE,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

[design/picp_in_if.sv]
// Input channel: one command beat (clear, append vertex or query point).
interface picp_in_if;
  import picp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FuncW-1:0]      func;
  logic signed [CoordW-1:0] vert_x;
  logic signed [CoordW-1:0] vert_y;
  logic signed [CoordW-1:0] pt_x;
  logic signed [CoordW-1:0] pt_y;
  logic signed [CoordW-1:0] pt_z;
  logic signed [CoordW-1:0] pt_w;

  modport source (
    output valid, func, vert_x, vert_y, pt_x, pt_y, pt_z, pt_w,
    input  ready
  );

  modport sink (
    input  valid, func, vert_x, vert_y, pt_x, pt_y, pt_z, pt_w,
    output ready
  );
endinterface

[design/picp_out_if.sv]
// Output channel: one result beat per command.
interface picp_out_if;
  import picp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 inside_res;
  logic [CountOutW-1:0] vertex_count;
  logic                 status;

  modport source (
    output valid, inside_res, vertex_count, status,
    input  ready
  );

  modport sink (
    input  valid, inside_res, vertex_count, status,
    output ready
  );
endinterface

[design/picp_edge_pipe.sv]
// Edge test pipeline: differences, two cross-product multiplies, sign compare.
`include "point_in_convex_polygon_unit_assert.svh"

module picp_edge_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  picp_pkg::edge_ctl_t ctl_i,
  input  picp_pkg::vertex_t   vtx_i,
  input  picp_pkg::coord_t    px_i,
  input  picp_pkg::coord_t    py_i,
  output picp_pkg::edge_sts_t sts_o
);
  import picp_pkg::*;

  vertex_t a_q;
  diff_t   hx_q, hy_q, dx_q, dy_q;
  prod_t   p1_q, p2_q;
  logic    d_v_q, m_v_q, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      m_v_q <= 1'b0;
      out_q <= 1'b0;
    end else begin
      d_v_q <= ctl_i.vld && !ctl_i.first;
      m_v_q <= d_v_q;
      if (ctl_i.clr) begin
        out_q <= 1'b0;
      end else if (m_v_q && (p1_q > p2_q)) begin
        out_q <= 1'b1;
      end
    end
  end

  // edge runs from a_q (previous vertex) to vtx_i
  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      a_q  <= vtx_i;
      hx_q <= DiffW'(px_i) - DiffW'(a_q.x);
      hy_q <= DiffW'(py_i) - DiffW'(a_q.y);
      dx_q <= DiffW'(a_q.x) - DiffW'(vtx_i.x);
      dy_q <= DiffW'(a_q.y) - DiffW'(vtx_i.y);
    end
    p1_q <= hx_q * dy_q;
    p2_q <= hy_q * dx_q;
  end

  assign sts_o.busy    = d_v_q || m_v_q;
  assign sts_o.outside = out_q;

  `PICP_ASSERT(a_mul_follows_diff, m_v_q |-> $past(d_v_q))
  `PICP_ASSERT(a_diff_needs_prev, d_v_q |-> $past(ctl_i.vld && !ctl_i.first))
  `PICP_ASSERT(a_flag_falls_on_clr, $fell(out_q) |-> $past(ctl_i.clr))

endmodule

[design/point_in_convex_polygon_unit.sv]
// Point-in-convex-polygon unit: vertex table, projection and edge walk.
//
// Usage: commands arrive as beats on in_i (valid/ready), one result beat per
// command leaves on out_o. func 0 clears the vertex table, 1 appends a
// vertex (dropped with status 1 when the table is full), 2 queries a point,
// 3 does nothing. The 2x4 Q1.14 transform sits in eight registers written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them only
// while the unit is idle; the block does not enforce it. Clear, append and
// no-op pass through ST_DONE, which loads the output register and raises
// out_o.valid. A query projects the point one component at a time on two
// shared 16x24 multipliers, finishes the sums and saturates, then reads
// n + 1 entries of the vertex RAM for n stored vertices (at most 16), one
// edge per cycle, drains the read and cross-product pipeline and loads the
// output register in ST_DONE. Queries with fewer than two vertices finish
// like a clear. One command is in flight at a time.
// A finished result waits in the output register; the next command is
// accepted meanwhile and completes once that register frees up, so a stall
// on out_o holds back at most one command.
// Reset empties the table (count 0) and loads the identity transform; RAM
// contents are not cleared and need no clearing pass.
`include "point_in_convex_polygon_unit_assert.svh"

module point_in_convex_polygon_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [picp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [picp_pkg::CoefW-1:0]     cfg_wdata_i,
  picp_in_if.sink                        in_i,
  picp_out_if.source                     out_o
);
  import picp_pkg::*;

  state_e state_q, state_d;

  coef_t row0_q [4];
  coef_t row1_q [4];

  logic [CntW-1:0] cnt_q;
  logic [1:0]      k_q;
  logic            pv_q;
  logic [CntW-1:0] rd_idx_q;
  logic            rd_v_q, rd_first_q;
  logic            status_q, walk_q;
  logic            out_valid_q;

  coord_t                     pt_q [4];
  logic signed [PtProdW-1:0]  prod0_q, prod1_q;
  logic signed [AccW-1:0]     acc0_q, acc1_q;
  coord_t                     px_q, py_q;

  vertex_t mem_q [MaxVertices];
  vertex_t rdata_q;

  logic                 out_inside_q, out_status_q;
  logic [CountOutW-1:0] out_cnt_q;

  logic            in_fire, full, mem_we, mem_re, out_load, edge_clr;
  logic [AddrW-1:0] rd_addr;
  edge_ctl_t       edge_ctl;
  edge_sts_t       edge_sts;

  function automatic coord_t sat_coord(input logic signed [AccW-1:0] a);
    logic signed [AccW-FracW-1:0] s;
    logic signed [AccW-FracW-1:0] hi, lo;
    s  = (AccW-FracW)'(a >>> FracW);
    hi = (AccW-FracW)'({1'b0, {(CoordW-1){1'b1}}});
    lo = ~hi;
    if (s > hi) begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end else if (s < lo) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      return s[CoordW-1:0];
    end
  endfunction

  assign full = (cnt_q >= CntW'(MaxVertices));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_i.func == FUNC_QUERY) && (cnt_q >= CntW'(2))) begin
            state_d = ST_PROJ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_PROJ: begin
        if (k_q == 2'd3) state_d = ST_ACC;
      end
      ST_ACC:   state_d = ST_SAT;
      ST_SAT:   state_d = ST_EDGE;
      ST_EDGE: begin
        if (rd_idx_q == cnt_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v_q && !edge_sts.busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    in_fire    = in_i.valid && (state_q == ST_IDLE);
    mem_we     = in_fire && (in_i.func == FUNC_APPEND) && !full;
    mem_re     = (state_q == ST_EDGE);
    // last read of the walk goes back to vertex 0 for the closing edge
    rd_addr    = (rd_idx_q == cnt_q) ? '0 : rd_idx_q[AddrW-1:0];
    out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
    edge_clr   = (state_q == ST_SAT);
  end

  assign edge_ctl.vld   = rd_v_q;
  assign edge_ctl.first = rd_first_q;
  assign edge_ctl.clr   = edge_clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      pv_q        <= 1'b0;
      rd_idx_q    <= '0;
      rd_v_q      <= 1'b0;
      rd_first_q  <= 1'b0;
      status_q    <= 1'b0;
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
      row0_q[0]   <= CoefOne;
      row0_q[1]   <= '0;
      row0_q[2]   <= '0;
      row0_q[3]   <= '0;
      row1_q[0]   <= '0;
      row1_q[1]   <= CoefOne;
      row1_q[2]   <= '0;
      row1_q[3]   <= '0;
    end else begin
      state_q    <= state_d;
      pv_q       <= (state_q == ST_PROJ);
      rd_v_q     <= mem_re;
      rd_first_q <= mem_re && (rd_idx_q == '0);

      if (in_fire) begin
        status_q <= (in_i.func == FUNC_APPEND) && full;
        walk_q   <= 1'b0;
        k_q      <= '0;
        if (in_i.func == FUNC_CLEAR) cnt_q <= '0;
        if (mem_we) cnt_q <= cnt_q + CntW'(1);
      end
      if (state_q == ST_PROJ) k_q <= k_q + 2'd1;
      if (state_q == ST_SAT) begin
        rd_idx_q <= '0;
        walk_q   <= 1'b1;
      end
      if (mem_re) rd_idx_q <= rd_idx_q + CntW'(1);

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_R0_C0: row0_q[0] <= cfg_wdata_i;
          CFG_R0_C1: row0_q[1] <= cfg_wdata_i;
          CFG_R0_C2: row0_q[2] <= cfg_wdata_i;
          CFG_R0_C3: row0_q[3] <= cfg_wdata_i;
          CFG_R1_C0: row1_q[0] <= cfg_wdata_i;
          CFG_R1_C1: row1_q[1] <= cfg_wdata_i;
          CFG_R1_C2: row1_q[2] <= cfg_wdata_i;
          CFG_R1_C3: row1_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // datapath and vertex RAM
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pt_q[0] <= in_i.pt_x;
      pt_q[1] <= in_i.pt_y;
      pt_q[2] <= in_i.pt_z;
      pt_q[3] <= in_i.pt_w;
    end
    prod0_q <= row0_q[k_q] * pt_q[k_q];
    prod1_q <= row1_q[k_q] * pt_q[k_q];
    if (in_fire) begin
      acc0_q <= '0;
      acc1_q <= '0;
    end else if (pv_q) begin
      acc0_q <= acc0_q + AccW'(prod0_q);
      acc1_q <= acc1_q + AccW'(prod1_q);
    end
    if (state_q == ST_SAT) begin
      px_q <= sat_coord(acc0_q);
      py_q <= sat_coord(acc1_q);
    end

    if (mem_we) mem_q[cnt_q[AddrW-1:0]] <= '{x: in_i.vert_x, y: in_i.vert_y};
    if (mem_re) rdata_q <= mem_q[rd_addr];

    if (out_load) begin
      out_inside_q <= walk_q && !edge_sts.outside;
      out_cnt_q    <= CountOutW'(cnt_q);
      out_status_q <= status_q;
    end
  end

  picp_edge_pipe u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (edge_ctl),
    .vtx_i  (rdata_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .sts_o  (edge_sts)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.inside_res   = out_inside_q;
  assign out_o.vertex_count = out_cnt_q;
  assign out_o.status       = out_status_q;

  `PICP_ASSERT(a_cnt_bounded, cnt_q <= CntW'(MaxVertices))
  `PICP_ASSERT(a_read_below_cnt, mem_re |-> CntW'(rd_addr) < cnt_q)
  `PICP_ASSERT(a_inside_needs_two, out_load && walk_q && !edge_sts.outside |-> cnt_q >= CntW'(2))
  `PICP_ASSERT(a_drop_only_full, out_load && status_q |-> cnt_q == CntW'(MaxVertices))

endmodule
